### hdl/tolerance_cluster_voter_defines.svh
// ---------------------------------------------------------------------------
// tolerance_cluster_voter_defines.svh
// Assertion macros shared by the voter RTL.
// ---------------------------------------------------------------------------
`ifndef TOLERANCE_CLUSTER_VOTER_DEFINES_SVH
`define TOLERANCE_CLUSTER_VOTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tcv_pkg.sv
// ---------------------------------------------------------------------------
// tcv_pkg
// Widths, codes and shared types of the tolerance cluster voter.
// ---------------------------------------------------------------------------
package tcv_pkg;

  localparam int NUM_CH      = 8;   // channel fields in one input item
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 4;
  localparam int TOL_W       = 31;
  localparam int ST_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 264; // 8 x 32 + 4, padded to bytes
  localparam int OUT_TDATA_W = 48;  // 32 + 4 + 8 + 1, padded to bytes

  // result status codes
  localparam logic [ST_W-1:0] ST_OK             = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_CONFIG     = 2'd1;
  localparam logic [ST_W-1:0] ST_COUNT_MISMATCH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;

  localparam logic [CNT_W-1:0] RST_ACTIVE = 4'd2;
  localparam logic [CNT_W-1:0] RST_THRESH = 4'd1;
  localparam logic [CNT_W-1:0] MIN_ACTIVE = 4'd2;

  typedef logic [NUM_CH-1:0][DATA_W-1:0] chan_vec_t;

  // pipeline load strobes handed to every lane
  typedef struct packed {
    logic load1;
    logic load2;
  } stage_en_t;

  // what the merge stage found
  typedef struct packed {
    logic [DATA_W-1:0] voted_value;
    logic [CNT_W-1:0]  cluster_size;
    logic [NUM_CH-1:0] dissent_mask;
    logic              consensus;
  } vote_t;

endpackage

### hdl/tcv_lane.sv
// ---------------------------------------------------------------------------
// tcv_lane
// One voting lane: agreement of its channel with all others, then its score.
// ---------------------------------------------------------------------------
module tcv_lane #(
  parameter int LANE = 0
) (
  input  logic                          clk,
  input  tcv_pkg::stage_en_t            en,
  input  logic [tcv_pkg::TOL_W-1:0]     tol,
  input  tcv_pkg::chan_vec_t            vals,
  input  logic [tcv_pkg::NUM_CH-1:0]    act_mask,  // stage-1 copy
  output logic [tcv_pkg::NUM_CH-1:0]    row_o,     // stage-2 agreement row
  output logic [tcv_pkg::CNT_W-1:0]     score_o    // stage-2 score
);

  logic [tcv_pkg::NUM_CH-1:0] row_nxt;
  logic [tcv_pkg::NUM_CH-1:0] row1_r;
  logic [tcv_pkg::NUM_CH-1:0] row2_r;
  logic [tcv_pkg::CNT_W-1:0]  score_nxt;
  logic [tcv_pkg::CNT_W-1:0]  score_r;

  // |a - b| in 33 bits against the tolerance
  always_comb begin
    logic [tcv_pkg::DATA_W:0] a;
    logic [tcv_pkg::DATA_W:0] b;
    logic [tcv_pkg::DATA_W:0] d;
    logic [tcv_pkg::DATA_W:0] mag;
    a = {vals[LANE][tcv_pkg::DATA_W-1], vals[LANE]};
    for (int j = 0; j < tcv_pkg::NUM_CH; j++) begin
      b   = {vals[j][tcv_pkg::DATA_W-1], vals[j]};
      d   = a - b;
      mag = d[tcv_pkg::DATA_W] ? (~d + 1'b1) : d;
      row_nxt[j] = (mag <= {2'b00, tol});
    end
  end

  // score counts active agreeing channels; an inactive lane scores zero
  always_comb begin
    logic [tcv_pkg::NUM_CH-1:0] hits;
    hits      = row1_r & act_mask;
    score_nxt = '0;
    for (int j = 0; j < tcv_pkg::NUM_CH; j++) begin
      score_nxt = score_nxt + {{(tcv_pkg::CNT_W-1){1'b0}}, hits[j]};
    end
    if (!act_mask[LANE]) begin
      score_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.load1) begin
      row1_r <= row_nxt;
    end
    if (en.load2) begin
      row2_r  <= row1_r;
      score_r <= score_nxt;
    end
  end

  assign row_o   = row2_r;
  assign score_o = score_r;

endmodule

### hdl/tcv_merge.sv
// ---------------------------------------------------------------------------
// tcv_merge
// Picks the first lane with the top score and builds the vote fields.
// ---------------------------------------------------------------------------
module tcv_merge #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic [MAX_CHANNELS-1:0][tcv_pkg::CNT_W-1:0]  scores,
  input  logic [MAX_CHANNELS-1:0][tcv_pkg::NUM_CH-1:0] rows,
  input  tcv_pkg::chan_vec_t                           vals,
  input  logic [tcv_pkg::NUM_CH-1:0]                   act_mask,
  input  logic [tcv_pkg::CNT_W-1:0]                    thresh,
  output tcv_pkg::vote_t                               vote
);

  always_comb begin
    logic [tcv_pkg::CNT_W-1:0]  best;
    logic [MAX_CHANNELS-1:0]    win_oh;
    logic [tcv_pkg::DATA_W-1:0] win_val;
    logic [tcv_pkg::NUM_CH-1:0] win_row;
    best   = '0;
    win_oh = '0;
    // strict compare keeps the lowest-numbered lane on a tie
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (scores[i] > best) begin
        best   = scores[i];
        win_oh = '0;
        win_oh[i] = 1'b1;
      end
    end
    win_val = '0;
    win_row = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      win_val = win_val | (vals[i] & {tcv_pkg::DATA_W{win_oh[i]}});
      win_row = win_row | (rows[i] & {tcv_pkg::NUM_CH{win_oh[i]}});
    end
    vote.voted_value  = win_val;
    vote.cluster_size = best;
    vote.dissent_mask = ~win_row & act_mask;
    vote.consensus    = (best >= thresh);
  end

endmodule

### hdl/tolerance_cluster_voter.sv
// ---------------------------------------------------------------------------
// tolerance_cluster_voter
// Inexact majority voter with tolerance over up to eight redundant readings.
// ---------------------------------------------------------------------------
//
//  port group  | dir | carries
//  ------------+-----+--------------------------------------------------------
//  cfg_*       | in  | register write: active_channels, agree_threshold, tol
//  in_t*       | in  | one frame: channel_0..channel_7, channel_count
//  out_t*      | out | one vote: status (tuser), value, cluster, mask, consensus
//
//  One item per cycle, sustained while out_tready holds. Three register stages: lane
//  compare (33-bit difference vs tolerance), lane score plus agreement row, then merge
//  into the output register, which drives out_tvalid once it holds an item.
//  rst_n is synchronous, active low; it empties the pipe and loads the
//  register reset values (2 channels, threshold 1, tolerance 0).
//  A stall on out_tready backs up stage by stage; empty stages keep taking
//  items, so in_tready drops only when all three stages hold an item and
//  out_tready is low.
//
`include "tolerance_cluster_voter_defines.svh"

module tolerance_cluster_voter #(
  parameter int MAX_CHANNELS = 8   // lanes built, 2..8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tcv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcv_pkg::TOL_W-1:0]          cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, low bit up: channel_0 .. channel_7 (32 each), channel_count (4), pad
  input  logic [tcv_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, low bit up: voted_value (32), cluster_size (4),
  // dissent_mask (8), consensus (1), pad
  output logic [tcv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: status (2)
  output logic [tcv_pkg::ST_W-1:0]           out_tuser
);

  localparam int CNT_W = tcv_pkg::CNT_W;
  localparam int NCH   = tcv_pkg::NUM_CH;

  // configuration
  logic [CNT_W-1:0]         active_r;
  logic [CNT_W-1:0]         thresh_r;
  logic [tcv_pkg::TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= tcv_pkg::RST_ACTIVE;
      thresh_r <= tcv_pkg::RST_THRESH;
      tol_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tcv_pkg::REG_ACTIVE: active_r <= cfg_wdata[CNT_W-1:0];
        tcv_pkg::REG_THRESH: thresh_r <= cfg_wdata[CNT_W-1:0];
        tcv_pkg::REG_TOL:    tol_r    <= cfg_wdata;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // input unpack and early checks
  tcv_pkg::chan_vec_t         in_vals;
  logic [CNT_W-1:0]           in_count;
  logic [NCH-1:0]             in_act;
  logic [tcv_pkg::ST_W-1:0]   in_status;
  logic                       cfg_bad;

  always_comb begin
    for (int j = 0; j < NCH; j++) begin
      in_vals[j] = in_tdata[j*tcv_pkg::DATA_W +: tcv_pkg::DATA_W];
      in_act[j]  = (CNT_W'(j) < active_r);
    end
    in_count = in_tdata[NCH*tcv_pkg::DATA_W +: CNT_W];
    cfg_bad  = (active_r < tcv_pkg::MIN_ACTIVE) || (active_r > CNT_W'(MAX_CHANNELS)) ||
               (thresh_r == '0) || (thresh_r > active_r);
    if (cfg_bad) begin
      in_status = tcv_pkg::ST_BAD_CONFIG;
    end else if (in_count != active_r) begin
      in_status = tcv_pkg::ST_COUNT_MISMATCH;
    end else begin
      in_status = tcv_pkg::ST_OK;
    end
  end

  // pipeline flow: each stage loads when empty or when its successor moves
  logic v1_r, v2_r, vout_r;
  logic v1_nxt, v2_nxt, vout_nxt;
  logic rdy1, rdy2, rdy_out;
  tcv_pkg::stage_en_t stage_en;

  assign rdy_out   = !vout_r || out_tready;
  assign rdy2      = !v2_r || rdy_out;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign stage_en.load1 = rdy1;
  assign stage_en.load2 = rdy2;

  assign v1_nxt   = rdy1 ? in_tvalid : v1_r;
  assign v2_nxt   = rdy2 ? v1_r : v2_r;
  assign vout_nxt = rdy_out ? v2_r : vout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      vout_r <= vout_nxt;
    end
  end

  // side data carried along with the lanes
  tcv_pkg::chan_vec_t       s1_vals_r, s2_vals_r;
  logic [NCH-1:0]           s1_act_r, s2_act_r;
  logic [CNT_W-1:0]         s1_thr_r, s2_thr_r;
  logic [tcv_pkg::ST_W-1:0] s1_status_r, s2_status_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_vals_r   <= in_vals;
      s1_act_r    <= in_act;
      s1_thr_r    <= thresh_r;
      s1_status_r <= in_status;
    end
    if (rdy2) begin
      s2_vals_r   <= s1_vals_r;
      s2_act_r    <= s1_act_r;
      s2_thr_r    <= s1_thr_r;
      s2_status_r <= s1_status_r;
    end
  end

  // one lane per possible channel
  logic [MAX_CHANNELS-1:0][NCH-1:0]   lane_row;
  logic [MAX_CHANNELS-1:0][CNT_W-1:0] lane_score;

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
    tcv_lane #(
      .LANE (l)
    ) u_lane (
      .clk      (clk),
      .en       (stage_en),
      .tol      (tol_r),
      .vals     (in_vals),
      .act_mask (s1_act_r),
      .row_o    (lane_row[l]),
      .score_o  (lane_score[l])
    );
  end

  tcv_pkg::vote_t vote;

  tcv_merge #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_merge (
    .scores   (lane_score),
    .rows     (lane_row),
    .vals     (s2_vals_r),
    .act_mask (s2_act_r),
    .thresh   (s2_thr_r),
    .vote     (vote)
  );

  // output register; error results carry all-zero fields
  tcv_pkg::vote_t           out_vote_r, out_vote_nxt;
  logic [tcv_pkg::ST_W-1:0] out_status_r;

  assign out_vote_nxt = (s2_status_r == tcv_pkg::ST_OK) ? vote : '0;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_vote_r   <= out_vote_nxt;
      out_status_r <= s2_status_r;
    end
  end

  assign out_tvalid = vout_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_vote_r.consensus, out_vote_r.dissent_mask,
                       out_vote_r.cluster_size, out_vote_r.voted_value};

  // checks
  `TCV_ASSERT_NOW(a_err_fields_zero,
    vout_r && (out_status_r != tcv_pkg::ST_OK), out_tdata == '0,
    "error result with nonzero fields")

  `TCV_ASSERT_NOW(a_ok_cluster_range,
    vout_r && (out_status_r == tcv_pkg::ST_OK),
    (out_vote_r.cluster_size != '0) && (out_vote_r.cluster_size <= CNT_W'(MAX_CHANNELS)),
    "cluster size out of range on ok result")

  `TCV_ASSERT_NOW(a_ready_has_room,
    in_tready, !v1_r || !v2_r || !vout_r || out_tready,
    "input taken while every stage is full and stalled")

  `TCV_ASSERT_NEXT(a_s2_holds_on_stall,
    v2_r && !rdy_out, v2_r && $stable(s2_vals_r) && $stable(lane_score),
    "stage 2 item lost or changed during stall")

endmodule
